FILE: rtl/npid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npid_pkg
// Shared types and constants of the nested priority interrupt dispatch unit:
// item layouts, status and operation codes, register indexes.
// ----------------------------------------------------------------------------
package npid_pkg;

   // Fixed field widths
   localparam int IRQ_W     = 6;
   localparam int LEVEL_W   = 5;
   localparam int MAP_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;

   // Defaults for the top-level parameters
   localparam int NUM_IRQS_DEF   = 64;
   localparam int NUM_LEVELS_DEF = 16;

   // Level value that marks no handler running
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL = 5'd16;

   // Operation codes
   localparam logic OP_RAISE = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PENDING    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESUMED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNREG      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DONE_IDLE  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HANDLER_PRESENT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MAP_0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MAP_1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MAP_2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_MAP_3     = 3'd4;

   typedef struct packed {
      logic             operation;
      logic [IRQ_W-1:0] irq;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IRQ_W-1:0]    dispatch_irq;
      logic [LEVEL_W-1:0]  active_level;
   } rsp_type;

   // Result of looking an IRQ up in the register bank
   typedef struct packed {
      logic             registered;
      logic [MAP_W-1:0] level;
   } lookup_type;

endpackage

FILE: rtl/npid_csr_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npid_csr_bank
// Handler-present mask and level map registers, with the lookup that turns
// an IRQ number into its registered flag and its clamped priority level.
// ----------------------------------------------------------------------------
module npid_csr_bank
   import npid_pkg::*;
#(
   parameter int NUM_IRQS   = NUM_IRQS_DEF,
   parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [IRQ_W-1:0]     irq,
   output lookup_type           lookup
);

   logic [CSR_W-1:0] handler_present_ff;
   logic [CSR_W-1:0] level_map_ff [4];
   logic [CSR_W-1:0] map_word;
   logic [MAP_W-1:0] raw_level;

   // Write registers; other indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         handler_present_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            level_map_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HANDLER_PRESENT: handler_present_ff <= csr_wdata;
            CSR_LEVEL_MAP_0:     level_map_ff[0] <= csr_wdata;
            CSR_LEVEL_MAP_1:     level_map_ff[1] <= csr_wdata;
            CSR_LEVEL_MAP_2:     level_map_ff[2] <= csr_wdata;
            CSR_LEVEL_MAP_3:     level_map_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pick the 4-bit entry for this IRQ and clamp it to the last level
   always_comb begin
      map_word  = level_map_ff[irq[5:4]];
      raw_level = map_word[{irq[3:0], 2'b00} +: MAP_W];
      lookup.registered = (7'(irq) < 7'(NUM_IRQS)) && handler_present_ff[irq];
      if (LEVEL_W'(raw_level) >= LEVEL_W'(NUM_LEVELS)) begin
         lookup.level = MAP_W'(NUM_LEVELS - 1);
      end else begin
         lookup.level = raw_level;
      end
   end

endmodule

FILE: rtl/nested_priority_interrupt_dispatch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_priority_interrupt_dispatch_unit
// Nesting priority interrupt controller. Each item is a raise of an IRQ or a
// handler-done event, and gives exactly one result item. A raise maps the IRQ
// to a level (lower is more urgent), marks it pending and dispatches it at
// once if it beats the running level; a done restores the level saved under
// the finished one and dispatches the first pending level between them.
// Saved levels and the IRQ recorded per level sit in two memories with
// registered reads. A raise, or a done while idle, passes through S_EVAL and
// S_OUT; a done that resumes also passes S_SCAN, and a done that dispatches a
// pending level passes S_SCAN and then S_FETCH, these extra states being the
// reads of the saved-level memory and then the source-IRQ memory. A new item
// is taken in the cycle after the previous one has moved into the output
// register, so the unit takes no new item while one is still in flight.
// ----------------------------------------------------------------------------
module nested_priority_interrupt_dispatch_unit
   import npid_pkg::*;
#(
   parameter int NUM_IRQS   = NUM_IRQS_DEF,
   parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam int LW = $clog2(NUM_LEVELS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FETCH = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff;
   lookup_type             lookup, look_ff;
   logic [LEVEL_W-1:0]     cur_ff, cur_in;
   logic [LEVEL_W-1:0]     restored_ff, restored_in;
   logic [LW-1:0]          hit_ff, hit_in;
   logic [NUM_LEVELS-1:0]  pending_ff, pending_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Memory ports
   logic [LEVEL_W-1:0]     saved_mem [NUM_LEVELS];
   logic [IRQ_W-1:0]       src_mem [NUM_LEVELS];
   logic                   saved_we, saved_re, src_we, src_re;
   logic [LW-1:0]          saved_waddr, saved_raddr, src_waddr, src_raddr;
   logic [LEVEL_W-1:0]     saved_wdata, saved_rdata_ff;
   logic [IRQ_W-1:0]       src_wdata, src_rdata_ff;

   // Scan result
   logic                   scan_found;
   logic [LW-1:0]          scan_idx;
   logic [LW-1:0]          raise_idx;

   npid_csr_bank #(
      .NUM_IRQS   (NUM_IRQS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_csr_bank (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .irq          (req_data.irq),
      .lookup       (lookup)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign raise_idx = look_ff.level[LW-1:0];

   // Find the lowest pending level at or above the finished one and more
   // urgent than the restored one
   always_comb begin
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (pending_ff[i] && (LEVEL_W'(i) >= cur_ff) && (LEVEL_W'(i) < saved_rdata_ff)) begin
            scan_found = 1'b1;
            scan_idx   = LW'(i);
         end
      end
   end

   // Sequencer: evaluate, read memories, update state, stage the result
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      restored_in  = restored_ff;
      hit_in       = hit_ff;
      pending_in   = pending_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      saved_we     = 1'b0;
      saved_re     = 1'b0;
      saved_waddr  = '0;
      saved_raddr  = '0;
      saved_wdata  = '0;
      src_we       = 1'b0;
      src_re       = 1'b0;
      src_waddr    = '0;
      src_raddr    = '0;
      src_wdata    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            res_in.dispatch_irq = '0;
            res_in.active_level = cur_ff;
            state_in            = S_OUT;
            if (req_ff.operation == OP_RAISE) begin
               if (!look_ff.registered) begin
                  res_in.status = STATUS_UNREG;
               end else begin
                  // Record the latest IRQ at its level
                  src_we    = 1'b1;
                  src_waddr = raise_idx;
                  src_wdata = req_ff.irq;
                  if (LEVEL_W'(look_ff.level) < cur_ff) begin
                     // Preempt: save the running level under the new one
                     saved_we              = 1'b1;
                     saved_waddr           = raise_idx;
                     saved_wdata           = cur_ff;
                     cur_in                = LEVEL_W'(look_ff.level);
                     pending_in[raise_idx] = 1'b0;
                     res_in.status         = STATUS_DISPATCHED;
                     res_in.dispatch_irq   = req_ff.irq;
                     res_in.active_level   = LEVEL_W'(look_ff.level);
                  end else begin
                     pending_in[raise_idx] = 1'b1;
                     res_in.status         = STATUS_PENDING;
                  end
               end
            end else if (cur_ff >= LEVEL_W'(NUM_LEVELS)) begin
               res_in.status = STATUS_DONE_IDLE;
            end else begin
               // Fetch the level saved under the finished one
               saved_re    = 1'b1;
               saved_raddr = cur_ff[LW-1:0];
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            if (scan_found) begin
               src_re      = 1'b1;
               src_raddr   = scan_idx;
               hit_in      = scan_idx;
               restored_in = saved_rdata_ff;
               state_in    = S_FETCH;
            end else begin
               cur_in              = saved_rdata_ff;
               res_in.status       = STATUS_RESUMED;
               res_in.dispatch_irq = '0;
               res_in.active_level = saved_rdata_ff;
               state_in            = S_OUT;
            end
         end

         S_FETCH: begin
            // Dispatch the pending level on top of the restored one
            saved_we            = 1'b1;
            saved_waddr         = hit_ff;
            saved_wdata         = restored_ff;
            pending_in[hit_ff]  = 1'b0;
            cur_in              = LEVEL_W'(hit_ff);
            res_in.status       = STATUS_DISPATCHED;
            res_in.dispatch_irq = src_rdata_ff;
            res_in.active_level = LEVEL_W'(hit_ff);
            state_in            = S_OUT;
         end

         S_OUT: begin
            // Hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= IDLE_LEVEL;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff  <= req_data;
         look_ff <= lookup;
      end
      restored_ff <= restored_in;
      hit_ff      <= hit_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // Saved-level memory
   always_ff @(posedge clock) begin
      if (saved_we) begin
         saved_mem[saved_waddr] <= saved_wdata;
      end
      if (saved_re) begin
         saved_rdata_ff <= saved_mem[saved_raddr];
      end
   end

   // Source-IRQ memory
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      if (src_re) begin
         src_rdata_ff <= src_mem[src_raddr];
      end
   end

endmodule

FILE: rtl/npid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npid_checker
// Port-level checks of the dispatch unit's result channel, bound to the top
// level.
// ----------------------------------------------------------------------------
module npid_checker
   import npid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Drop the output after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Zero the IRQ field unless dispatching
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_DISPATCHED) |-> rsp_data.dispatch_irq == '0)
      else $error("dispatch_irq set without a dispatch");

   // A dispatch leaves a handler running; done while idle stays idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_DISPATCHED) |-> rsp_data.active_level != IDLE_LEVEL)
      else $error("dispatch reported idle level");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_DONE_IDLE) |-> rsp_data.active_level == IDLE_LEVEL)
      else $error("done while idle left a level active");

endmodule

bind nested_priority_interrupt_dispatch_unit npid_checker u_npid_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/nested_priority_interrupt_dispatch_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_priority_interrupt_dispatch_unit_tb
// Self-checking bench for the nesting interrupt controller. A scoreboard keeps
// its own copy of the level stack, the pending levels and the register bank,
// predicts the one result of every accepted event and compares it field by
// field with what comes out. A short directed sequence walks through nesting,
// resume and error cases. Random phases under different register settings
// follow, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
import npid_pkg::*;

class irq_dispatch_scoreboard;
   localparam int LEVELS = NUM_LEVELS_DEF;

   logic [CSR_W-1:0]   handler_mask;
   logic [CSR_W-1:0]   level_words[4];
   logic [LEVEL_W-1:0] serving_level;
   bit                 level_waiting[LEVELS];
   logic [IRQ_W-1:0]   level_irq[LEVELS];
   logic [LEVEL_W-1:0] resume_level[LEVELS];
   rsp_type            expected_q[$];
   int unsigned        fail_count;

   function new();
      handler_mask  = '0;
      serving_level = IDLE_LEVEL;
      fail_count    = 0;
      foreach (level_words[i]) level_words[i] = '0;
      for (int i = 0; i < LEVELS; i++) begin
         level_waiting[i] = 1'b0;
         level_irq[i]     = '0;
         resume_level[i]  = IDLE_LEVEL;
      end
   endfunction

   // Mirror a register write; unknown indexes are dropped
   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      case (idx)
         CSR_HANDLER_PRESENT: handler_mask = value;
         CSR_LEVEL_MAP_0:     level_words[0] = value;
         CSR_LEVEL_MAP_1:     level_words[1] = value;
         CSR_LEVEL_MAP_2:     level_words[2] = value;
         CSR_LEVEL_MAP_3:     level_words[3] = value;
         default: ;
      endcase
   endfunction

   // Start the handler at a level: save the running level under it
   function logic [IRQ_W-1:0] start_level(int lvl);
      level_waiting[lvl] = 1'b0;
      resume_level[lvl]  = serving_level;
      serving_level      = LEVEL_W'(lvl);
      return level_irq[lvl];
   endfunction

   // Predict the result of one accepted event and queue it
   function void note_event(req_type ev);
      rsp_type exp_rsp;
      int      lvl;
      int      scan;
      exp_rsp = '0;
      if (ev.operation == OP_RAISE) begin
         if (!handler_mask[ev.irq]) begin
            exp_rsp.status = STATUS_UNREG;
         end else begin
            lvl = int'(level_words[ev.irq[5:4]][ev.irq[3:0]*MAP_W +: MAP_W]);
            if (lvl >= LEVELS) lvl = LEVELS - 1;
            level_waiting[lvl] = 1'b1;
            level_irq[lvl]     = ev.irq;
            if (lvl < serving_level) begin
               exp_rsp.dispatch_irq = start_level(lvl);
               exp_rsp.status       = STATUS_DISPATCHED;
            end else begin
               exp_rsp.status = STATUS_PENDING;
            end
         end
      end else if (serving_level >= LEVELS) begin
         exp_rsp.status = STATUS_DONE_IDLE;
      end else begin
         // Pop one nesting level, then look for a pending level more urgent than the restored one
         scan                = int'(serving_level);
         serving_level       = resume_level[scan];
         resume_level[scan]  = IDLE_LEVEL;
         while (scan < LEVELS && scan < serving_level && !level_waiting[scan]) scan++;
         if (scan < LEVELS && scan < serving_level) begin
            exp_rsp.dispatch_irq = start_level(scan);
            exp_rsp.status       = STATUS_DISPATCHED;
         end else begin
            exp_rsp.status = STATUS_RESUMED;
         end
      end
      exp_rsp.active_level = serving_level;
      expected_q.push_back(exp_rsp);
   endfunction

   // Compare one result item with the oldest prediction
   function void check_result(rsp_type got);
      rsp_type exp_rsp;
      if (expected_q.size() == 0) begin
         $error("unexpected result item: status %0d dispatch_irq %0d active_level %0d",
                got.status, got.dispatch_irq, got.active_level);
         fail_count++;
         return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.status !== exp_rsp.status) begin
         $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
         fail_count++;
      end
      if (got.dispatch_irq !== exp_rsp.dispatch_irq) begin
         $error("dispatch_irq: expected %0d, got %0d", exp_rsp.dispatch_irq, got.dispatch_irq);
         fail_count++;
      end
      if (got.active_level !== exp_rsp.active_level) begin
         $error("active_level: expected %0d, got %0d", exp_rsp.active_level, got.active_level);
         fail_count++;
      end
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction
endclass

module nested_priority_interrupt_dispatch_unit_tb;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_ITEMS    = 165;
   localparam int NOISE_ITEMS    = 30;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;

   irq_dispatch_scoreboard sb;
   int                     gap_max = 4;
   int                     quiet_cycles = 0;

   nested_priority_interrupt_dispatch_unit dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic req_type make_event(logic op, logic [IRQ_W-1:0] irq);
      req_type ev;
      ev.operation = op;
      ev.irq       = irq;
      return ev;
   endfunction

   function automatic logic [CSR_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly done or registered raises; now and then any IRQ at all
   function automatic req_type rand_event(logic [CSR_W-1:0] mask);
      logic [IRQ_W-1:0] irq;
      irq = IRQ_W'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 4) return make_event(OP_DONE, irq);
      if (mask != '0 && $urandom_range(0, 4) != 0) begin
         while (!mask[irq]) irq = IRQ_W'($urandom_range(0, 63));
      end
      return make_event(OP_RAISE, irq);
   endfunction

   // Write one register; the enable stays up for back-to-back writes
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic load_config(input logic [CSR_W-1:0] mask, input logic [CSR_W-1:0] m0,
                              input logic [CSR_W-1:0] m1, input logic [CSR_W-1:0] m2,
                              input logic [CSR_W-1:0] m3);
      write_csr(CSR_HANDLER_PRESENT, mask);
      write_csr(CSR_LEVEL_MAP_0, m0);
      write_csr(CSR_LEVEL_MAP_1, m1);
      write_csr(CSR_LEVEL_MAP_2, m2);
      write_csr(CSR_LEVEL_MAP_3, m3);
      csr_write_en <= 1'b0;
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic send_event(input req_type ev);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sb.note_event(ev);
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stall before each item, then take and check it
   initial begin
      int      gap;
      rsp_type got;
      rsp_ready <= 1'b0;
      do @(negedge clock); while (reset);
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         got = rsp_data;
         @(posedge clock);
         sb.check_result(got);
      end
   end

   // Watchdog: end the run when no item moves for too long
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [CSR_W-1:0] mask;
      logic [CSR_W-1:0] m0;
      logic [CSR_W-1:0] m1;
      logic [CSR_W-1:0] m2;
      logic [CSR_W-1:0] m3;
      int               n_items;

      sb = new();
      reset        <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_valid    <= 1'b0;
      req_data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nothing registered yet: done while idle and unregistered raises
      send_event(make_event(OP_DONE, 6'd0));
      send_event(make_event(OP_RAISE, 6'd0));
      send_event(make_event(OP_RAISE, 6'd63));
      drain();

      // Unused indexes must not disturb the bank
      for (int idx = int'(CSR_LEVEL_MAP_3) + 1; idx < (1 << CSR_IDX_W); idx++)
         write_csr(CSR_IDX_W'(idx), '1);
      // IRQ n -> level n for 0..15, IRQ 32..47 at level 15, IRQ 48 at 3, IRQ 63 at 7
      load_config(~64'h2, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF, '1,
                  64'h7000_0000_0000_0003);

      // Nest three deep, then unwind through scan, resume and idle
      send_event(make_event(OP_RAISE, 6'd15));
      send_event(make_event(OP_RAISE, 6'd32));
      send_event(make_event(OP_RAISE, 6'd63));
      send_event(make_event(OP_RAISE, 6'd10));
      send_event(make_event(OP_RAISE, 6'd0));
      send_event(make_event(OP_RAISE, 6'd1));
      send_event(make_event(OP_RAISE, 6'd48));
      send_event(make_event(OP_RAISE, 6'd0));
      repeat (8) send_event(make_event(OP_DONE, 6'd63));
      drain();

      // Random phases, each under its own register setting
      for (int phase = 0; phase < 6; phase++) begin
         mask    = '1;
         m0      = rand_word();
         m1      = rand_word();
         m2      = rand_word();
         m3      = rand_word();
         n_items = PHASE_ITEMS;
         gap_max = 4;
         case (phase)
            1, 4: mask = rand_word();
            2: begin
               m0 = '0; m1 = '0; m2 = '0; m3 = '0;
               gap_max = 0;
            end
            3: begin
               m0 = '1; m1 = '1; m2 = '1; m3 = '1;
            end
            5: begin
               mask    = '0;
               n_items = NOISE_ITEMS;
            end
            default: ;
         endcase
         load_config(mask, m0, m1, m2, m3);
         repeat (n_items) send_event(rand_event(mask));
         drain();
      end

      if (sb.fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/npid_pkg.sv
rtl/npid_csr_bank.sv
rtl/nested_priority_interrupt_dispatch_unit.sv
rtl/npid_checker.sv
tb/nested_priority_interrupt_dispatch_unit_tb.sv
